### hw/rtl/ctok_pkg.sv
// shared types, codes and lookup functions for the source tokenizer
`default_nettype none
package ctok_pkg;

	localparam int POS_BITS        = 16;
	localparam int KEYWORD_MAX_LEN = 6;
	localparam int WIN_BITS        = 8 * (KEYWORD_MAX_LEN + 1);
	localparam int QDEPTH          = 4;
	localparam int QPTR_W          = $clog2(QDEPTH);
	localparam int QCNT_W          = $clog2(QDEPTH + 1);

	localparam logic [15:0] LINE_MAX = 16'hFFFF;

	// scan modes
	localparam logic [3:0] M_IDLE     = 4'd0;
	localparam logic [3:0] M_OP       = 4'd1;
	localparam logic [3:0] M_SLASH    = 4'd2;
	localparam logic [3:0] M_LINE     = 4'd3;
	localparam logic [3:0] M_BLK      = 4'd4;
	localparam logic [3:0] M_BLK_STAR = 4'd5;
	localparam logic [3:0] M_WORD     = 4'd6;
	localparam logic [3:0] M_NUM      = 4'd7;
	localparam logic [3:0] M_STR      = 4'd8;

	// token kinds
	localparam logic [5:0] K_INT_LIT    = 6'd0;
	localparam logic [5:0] K_FLOAT_LIT  = 6'd1;
	localparam logic [5:0] K_STRING_LIT = 6'd2;
	localparam logic [5:0] K_IDENT      = 6'd3;
	localparam logic [5:0] K_KW_INT     = 6'd4;
	localparam logic [5:0] K_KW_FLOAT   = 6'd5;
	localparam logic [5:0] K_KW_STRING  = 6'd6;
	localparam logic [5:0] K_KW_BOOL    = 6'd7;
	localparam logic [5:0] K_KW_VOID    = 6'd8;
	localparam logic [5:0] K_KW_LIST    = 6'd9;
	localparam logic [5:0] K_KW_TRUE    = 6'd10;
	localparam logic [5:0] K_KW_FALSE   = 6'd11;
	localparam logic [5:0] K_KW_IF      = 6'd12;
	localparam logic [5:0] K_KW_ELSE    = 6'd13;
	localparam logic [5:0] K_KW_WHILE   = 6'd14;
	localparam logic [5:0] K_KW_RETURN  = 6'd15;
	localparam logic [5:0] K_PLUS       = 6'd16;
	localparam logic [5:0] K_MINUS      = 6'd17;
	localparam logic [5:0] K_STAR       = 6'd18;
	localparam logic [5:0] K_SLASH      = 6'd19;
	localparam logic [5:0] K_PERCENT    = 6'd20;
	localparam logic [5:0] K_ASSIGN     = 6'd21;
	localparam logic [5:0] K_COMMA      = 6'd22;
	localparam logic [5:0] K_SEMI       = 6'd23;
	localparam logic [5:0] K_ANDAND     = 6'd24;
	localparam logic [5:0] K_OROR       = 6'd25;
	localparam logic [5:0] K_LPAREN     = 6'd26;
	localparam logic [5:0] K_RPAREN     = 6'd27;
	localparam logic [5:0] K_LBRACE     = 6'd28;
	localparam logic [5:0] K_RBRACE     = 6'd29;
	localparam logic [5:0] K_LBRACK     = 6'd30;
	localparam logic [5:0] K_RBRACK     = 6'd31;
	localparam logic [5:0] K_DOT        = 6'd32;
	localparam logic [5:0] K_EOF        = 6'd33;
	localparam logic [5:0] K_ERROR      = 6'd34;
	localparam logic [5:0] K_GT         = 6'd35;
	localparam logic [5:0] K_LT         = 6'd36;
	localparam logic [5:0] K_GE         = 6'd37;
	localparam logic [5:0] K_LE         = 6'd38;
	localparam logic [5:0] K_EQEQ       = 6'd39;
	localparam logic [5:0] K_NE         = 6'd40;
	localparam logic [5:0] K_NOT        = 6'd41;

	// error codes
	localparam logic [2:0] E_NONE       = 3'd0;
	localparam logic [2:0] E_OPEN_CMT   = 3'd1;
	localparam logic [2:0] E_LONE_AND   = 3'd2;
	localparam logic [2:0] E_LONE_OR    = 3'd3;
	localparam logic [2:0] E_SECOND_DOT = 3'd4;
	localparam logic [2:0] E_BAD_CHAR   = 3'd5;
	localparam logic [2:0] E_OPEN_STR   = 3'd6;

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
		logic [15:0] line;
		logic [2:0]  err;
		logic [7:0]  bad;
		logic        last;
	} tok_t;

	typedef struct packed {
		logic [1:0] n;
		tok_t       r0;
		tok_t       r1;
	} tok_pair_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// keyword match on the right-aligned window of recent word bytes
	function automatic logic [5:0] kw_kind(input logic [WIN_BITS-1:0] w);
		logic [5:0] k;
		k = K_IDENT;
		if (w == WIN_BITS'("int"))         k = K_KW_INT;
		else if (w == WIN_BITS'("float"))  k = K_KW_FLOAT;
		else if (w == WIN_BITS'("bool"))   k = K_KW_BOOL;
		else if (w == WIN_BITS'("void"))   k = K_KW_VOID;
		else if (w == WIN_BITS'("list"))   k = K_KW_LIST;
		else if (w == WIN_BITS'("true"))   k = K_KW_TRUE;
		else if (w == WIN_BITS'("false"))  k = K_KW_FALSE;
		else if (w == WIN_BITS'("if"))     k = K_KW_IF;
		else if (w == WIN_BITS'("else"))   k = K_KW_ELSE;
		else if (w == WIN_BITS'("while"))  k = K_KW_WHILE;
		else if (w == WIN_BITS'("return")) k = K_KW_RETURN;
		else if (w == WIN_BITS'("string")) k = K_KW_STRING;
		return k;
	endfunction

	// single character tokens, zero when the byte is none of them
	function automatic logic [5:0] op_kind(input logic [7:0] c);
		logic [5:0] k;
		k = 6'd0;
		case (c)
			"+": k = K_PLUS;
			"-": k = K_MINUS;
			"*": k = K_STAR;
			"%": k = K_PERCENT;
			",": k = K_COMMA;
			";": k = K_SEMI;
			"(": k = K_LPAREN;
			")": k = K_RPAREN;
			"{": k = K_LBRACE;
			"}": k = K_RBRACE;
			"[": k = K_LBRACK;
			"]": k = K_RBRACK;
			".": k = K_DOT;
			default: k = 6'd0;
		endcase
		return k;
	endfunction

	function automatic logic [15:0] sat_len(input logic [POS_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'd65535) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic tok_t mk_tok(input logic [5:0] kind, input logic [POS_BITS-1:0] start,
			input logic [15:0] len, input logic [15:0] line, input logic [2:0] err,
			input logic [7:0] bad);
		tok_t t;
		t.kind   = kind;
		t.start  = 16'(start);
		t.length = len;
		t.line   = line;
		t.err    = err;
		t.bad    = bad;
		t.last   = 1'b0;
		return t;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/ctok_scan.sv
// scanner state and per-byte token logic, up to two tokens per byte
`default_nettype none
module ctok_scan import ctok_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      step,
	input  wire logic [7:0] byte_s1,
	output tok_pair_t      res
);

	logic [3:0]          mode_q, mode_d;
	logic [7:0]          pend_q, pend_d;
	logic [WIN_BITS-1:0] win_q, win_d;
	logic [POS_BITS-1:0] pos_q, pos_d;
	logic [15:0]         line_q, line_d;
	logic [POS_BITS-1:0] tbeg_q, tbeg_d;
	logic [15:0]         cline_q, cline_d;
	logic                dot_q, dot_d;

	always_comb begin
		logic [7:0]          c;
		logic                redo;
		logic                ended;
		logic                line_up;
		logic                e0_v, e1_v;
		tok_t                e0, e1;
		logic [5:0]          two;
		logic [5:0]          ok;
		logic [15:0]         span;
		logic [POS_BITS-1:0] pmax;

		c       = byte_s1;
		redo    = 1'b0;
		ended   = 1'b0;
		line_up = 1'b0;
		e0_v    = 1'b0;
		e1_v    = 1'b0;
		e0      = '0;
		e1      = '0;
		two     = 6'd0;
		ok      = op_kind(c);
		pmax    = {POS_BITS{1'b1}};
		span    = sat_len((pos_q >= tbeg_q) ? pos_q - tbeg_q : '0);

		mode_d  = mode_q;
		pend_d  = pend_q;
		win_d   = win_q;
		pos_d   = pos_q;
		line_d  = line_q;
		tbeg_d  = tbeg_q;
		cline_d = cline_q;
		dot_d   = dot_q;

		unique case (mode_q) inside
			M_OP: begin
				if (c == "=" && pend_q == ">") two = K_GE;
				else if (c == "=" && pend_q == "<") two = K_LE;
				else if (c == "=" && pend_q == "!") two = K_NE;
				else if (c == "=" && pend_q == "=") two = K_EQEQ;
				else if (c == "&" && pend_q == "&") two = K_ANDAND;
				else if (c == "|" && pend_q == "|") two = K_OROR;
				e0_v = 1'b1;
				if (two != 6'd0) begin
					e0 = mk_tok(two, tbeg_q, 16'd2, line_q, E_NONE, 8'd0);
					mode_d = M_IDLE;
				end else begin
					redo = 1'b1;
					case (pend_q)
						">": e0 = mk_tok(K_GT, tbeg_q, 16'd1, line_q, E_NONE, 8'd0);
						"<": e0 = mk_tok(K_LT, tbeg_q, 16'd1, line_q, E_NONE, 8'd0);
						"!": e0 = mk_tok(K_NOT, tbeg_q, 16'd1, line_q, E_NONE, 8'd0);
						"=": e0 = mk_tok(K_ASSIGN, tbeg_q, 16'd1, line_q, E_NONE, 8'd0);
						"&": e0 = mk_tok(K_ERROR, tbeg_q, 16'd1, line_q, E_LONE_AND, "&");
						default: e0 = mk_tok(K_ERROR, tbeg_q, 16'd1, line_q, E_LONE_OR, "|");
					endcase
				end
			end
			M_SLASH: begin
				if (c == "/") begin
					mode_d = M_LINE;
				end else if (c == "*") begin
					mode_d  = M_BLK;
					cline_d = line_q;
				end else begin
					e0_v = 1'b1;
					e0   = mk_tok(K_SLASH, tbeg_q, 16'd1, line_q, E_NONE, 8'd0);
					redo = 1'b1;
				end
			end
			M_LINE: begin
				if (c == "\n") begin
					line_up = 1'b1;
					mode_d  = M_IDLE;
				end else if (c == 8'd0) begin
					redo = 1'b1;
				end
			end
			M_BLK, M_BLK_STAR: begin
				if (c == 8'd0) begin
					e0_v = 1'b1;
					e0   = mk_tok(K_ERROR, tbeg_q, span, cline_q, E_OPEN_CMT, 8'd0);
					redo = 1'b1;
				end else if (c == "/" && mode_q == M_BLK_STAR) begin
					mode_d = M_IDLE;
				end else if (c == "*") begin
					mode_d = M_BLK_STAR;
				end else begin
					line_up = (c == "\n");
					mode_d  = M_BLK;
				end
			end
			M_WORD: begin
				if (is_alpha(c) || is_digit(c) || c == "_") begin
					win_d = {win_q[WIN_BITS-9:0], c};
				end else begin
					e0_v = 1'b1;
					e0   = mk_tok(kw_kind(win_q), tbeg_q, span, line_q, E_NONE, 8'd0);
					redo = 1'b1;
				end
			end
			M_NUM: begin
				if (is_digit(c)) begin
					dot_d = dot_q;
				end else if (c == "." && !dot_q) begin
					dot_d = 1'b1;
				end else if (c == ".") begin
					e0_v = 1'b1;
					e0   = mk_tok(K_ERROR, tbeg_q, span, line_q, E_SECOND_DOT, 8'd0);
					redo = 1'b1;
				end else begin
					e0_v = 1'b1;
					e0   = mk_tok(dot_q ? K_FLOAT_LIT : K_INT_LIT, tbeg_q, span, line_q,
						E_NONE, 8'd0);
					redo = 1'b1;
				end
			end
			M_STR: begin
				if (c == "\"") begin
					e0_v   = 1'b1;
					e0     = mk_tok(K_STRING_LIT, tbeg_q, span, line_q, E_NONE, 8'd0);
					mode_d = M_IDLE;
				end else if (c == 8'd0) begin
					e0_v = 1'b1;
					e0   = mk_tok(K_ERROR, tbeg_q, span, line_q, E_OPEN_STR, 8'd0);
					redo = 1'b1;
				end
			end
			default: redo = 1'b1;
		endcase

		// the byte starts afresh from idle
		if (redo) begin
			mode_d = M_IDLE;
			if (c == 8'd0) begin
				e1_v  = 1'b1;
				e1    = mk_tok(K_EOF, pos_q, 16'd0, line_q, E_NONE, 8'd0);
				ended = 1'b1;
			end else if (c == " " || c == "\t" || c == "\r") begin
				mode_d = M_IDLE;
			end else if (c == "\n") begin
				line_up = 1'b1;
			end else if (c == "/") begin
				mode_d = M_SLASH;
				tbeg_d = pos_q;
			end else if (c == ">" || c == "<" || c == "!" || c == "=" || c == "&" ||
					c == "|") begin
				mode_d = M_OP;
				pend_d = c;
				tbeg_d = pos_q;
			end else if (is_alpha(c) || c == "_") begin
				mode_d = M_WORD;
				win_d  = WIN_BITS'(c);
				tbeg_d = pos_q;
			end else if (is_digit(c)) begin
				mode_d = M_NUM;
				dot_d  = 1'b0;
				tbeg_d = pos_q;
			end else if (c == "\"") begin
				mode_d = M_STR;
				tbeg_d = (pos_q < pmax) ? pos_q + 1'b1 : pos_q;
			end else begin
				e1_v = 1'b1;
				if (ok != 6'd0) e1 = mk_tok(ok, pos_q, 16'd1, line_q, E_NONE, 8'd0);
				else e1 = mk_tok(K_ERROR, pos_q, 16'd1, line_q, E_BAD_CHAR, c);
			end
		end

		if (line_up && line_q < LINE_MAX) line_d = line_q + 16'd1;

		if (ended) begin
			mode_d  = M_IDLE;
			pend_d  = 8'd0;
			win_d   = '0;
			pos_d   = '0;
			line_d  = 16'd1;
			tbeg_d  = '0;
			cline_d = 16'd1;
			dot_d   = 1'b0;
		end else if (pos_q < pmax) begin
			pos_d = pos_q + 1'b1;
		end

		// pack in order, flag the final token of this byte
		if (e0_v) begin
			res.r0 = e0;
			res.r1 = e1;
			res.n  = e1_v ? 2'd2 : 2'd1;
		end else begin
			res.r0 = e1;
			res.r1 = e1;
			res.n  = e1_v ? 2'd1 : 2'd0;
		end
		if (res.n == 2'd2) res.r1.last = 1'b1;
		else res.r0.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			pend_q  <= 8'd0;
			win_q   <= '0;
			pos_q   <= '0;
			line_q  <= 16'd1;
			tbeg_q  <= '0;
			cline_q <= 16'd1;
			dot_q   <= 1'b0;
		end else if (step) begin
			mode_q  <= mode_d;
			pend_q  <= pend_d;
			win_q   <= win_d;
			pos_q   <= pos_d;
			line_q  <= line_d;
			tbeg_q  <= tbeg_d;
			cline_q <= cline_d;
			dot_q   <= dot_d;
		end
	end

`ifndef SYNTH
	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != 16'd0 && cline_q != 16'd0)
		else $error("line count reached zero");

	a_end_gives_token: assert property (@(posedge clk) disable iff (!arst_n)
		step && byte_s1 == 8'd0 |-> res.n != 2'd0)
		else $error("end of source produced no token");

	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step && byte_s1 == 8'd0 |=> mode_q == M_IDLE && pos_q == '0 && line_q == 16'd1)
		else $error("scanner did not restart after end of source");
`endif

endmodule
`default_nettype wire

### hw/rtl/ctok_outq.sv
// result queue, takes up to two tokens a cycle and hands out one
`default_nettype none
module ctok_outq import ctok_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire tok_pair_t res,
	output logic           room,
	output logic           m_valid,
	input  wire logic      m_ready,
	output tok_t           m_tok
);

	tok_t              q_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [1:0]        n_push;
	logic              pop;

	assign n_push  = push ? res.n : 2'd0;
	assign m_valid = cnt_q != '0;
	assign pop     = m_valid && m_ready;
	assign m_tok   = q_q[rd_q];
	// two free slots needed before the scanner may take a byte
	assign room    = cnt_q <= QCNT_W'(QDEPTH - 2);

	always_ff @(posedge clk) begin
		for (int i = 0; i < QDEPTH; i++) begin
			if (n_push != 2'd0 && wr_q == QPTR_W'(i)) q_q[i] <= res.r0;
			else if (n_push == 2'd2 && QPTR_W'(wr_q + 1'b1) == QPTR_W'(i)) q_q[i] <= res.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= QPTR_W'(wr_q + n_push);
			rd_q  <= QPTR_W'(rd_q + pop);
			cnt_q <= QCNT_W'(cnt_q + n_push - pop);
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("result queue overflow");

	a_push_with_room: assert property (@(posedge clk) disable iff (!arst_n)
		n_push != 2'd0 |-> cnt_q <= QCNT_W'(QDEPTH - 2))
		else $error("tokens pushed without room");

	a_head_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid && !m_ready |=> m_valid && $stable(m_tok))
		else $error("head word changed while waiting");
`endif

endmodule
`default_nettype wire

### hw/rtl/c_like_source_tokenizer_core.sv
// top level of the source tokenizer: input register, scanner, result queue
//
//  port group   dir  word                        handshake
//  s_axis_*     in   source byte, 0 ends source  tvalid/tready
//  m_axis_*     out  one token                   tvalid/tready, tlast = last of byte
//
// one byte a cycle while the queue has room: a byte is held in the input register,
// then the scanner logic updates its state and writes up to two tokens into a
// four entry queue. a byte that yields two tokens leaves it in two transfers.
// the input side stalls only while fewer than two queue slots are free.
// reset returns the scanner to idle at offset 0, line 1; byte 0 does the same.
`default_nettype none
module c_like_source_tokenizer_core import ctok_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] src_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,   // tok_start, tok_length, tok_line, err_code, bad_char
	output logic [5:0]       m_axis_tuser,   // [5:0] tok_kind
	output logic             m_axis_tlast    // last token for this byte
);

	logic      valid_s1;
	logic [7:0] byte_s1;
	logic      room;
	logic      step;
	tok_pair_t res;
	tok_t      tok;

	assign step          = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) byte_s1 <= s_axis_tdata;
	end

	ctok_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.byte_s1 (byte_s1),
		.res     (res)
	);

	ctok_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (step),
		.res     (res),
		.room    (room),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.m_tok   (tok)
	);

	assign m_axis_tdata = {5'd0, tok.bad, tok.err, tok.line, tok.length, tok.start};
	assign m_axis_tuser = tok.kind;
	assign m_axis_tlast = tok.last;

endmodule
`default_nettype wire
